[sv/mvva_pkg.sv]
// Package for the mixed Voronoi vertex area block: word types, widths, latencies.
// No dependencies; used by every other file of the block except mvva_delay.
`timescale 1ns / 1ps
package mvva_pkg;

  localparam int unsigned COORD_W   = 16;
  localparam int unsigned AREA_W    = 33;
  localparam int unsigned MUL_W     = 36;   // operand width of the split multiplier
  localparam int unsigned SQ_W      = 70;   // squared cross magnitude, numerators
  localparam int unsigned ROOT_W    = 36;
  localparam int unsigned DEN_W     = 39;
  localparam int unsigned SQRT_LAT  = ROOT_W;
  localparam int unsigned DIV_LAT   = AREA_W + 1;
  localparam int unsigned PIPE_LAT  = 7 + SQRT_LAT + DIV_LAT + 1;

  typedef struct packed {
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic signed [COORD_W-1:0] a_z;
    logic signed [COORD_W-1:0] b_x;
    logic signed [COORD_W-1:0] b_y;
    logic signed [COORD_W-1:0] b_z;
    logic signed [COORD_W-1:0] c_x;
    logic signed [COORD_W-1:0] c_y;
    logic signed [COORD_W-1:0] c_z;
  } in_word_t;

  typedef struct packed {
    logic [AREA_W-1:0] area_a;
    logic [AREA_W-1:0] area_b;
    logic [AREA_W-1:0] area_c;
    logic              degenerate;
  } out_word_t;

  // per-triangle case flags carried alongside the long arithmetic
  typedef struct packed {
    logic degen;
    logic obt_a;
    logic obt_b;
    logic obt_c;
  } case_flags_t;

endpackage

[sv/mvva_if.sv]
// Valid/ready channel interfaces for triangle input words and area output words.
// Depends on mvva_pkg.
`timescale 1ns / 1ps
interface mvva_in_if;
  logic               valid;
  logic               ready;
  mvva_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mvva_out_if;
  logic                valid;
  logic                ready;
  mvva_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/mvva_delay.sv]
// Enabled delay line of fixed depth, used to align side data with the long units.
// No dependencies.
`timescale 1ns / 1ps
module mvva_delay #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] sh_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sh_q[0] <= d_i;
      for (int k = 1; k < DEPTH; k++) begin
        sh_q[k] <= sh_q[k-1];
      end
    end
  end

  assign q_o = sh_q[DEPTH-1];

endmodule

[sv/mvva_mul.sv]
// Two-stage unsigned multiplier: 18x18 partial products, then their sum.
// Depends on mvva_pkg.
`timescale 1ns / 1ps
module mvva_mul (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [mvva_pkg::MUL_W-1:0]    a_i,
  input  logic [mvva_pkg::MUL_W-1:0]    b_i,
  output logic [2*mvva_pkg::MUL_W-1:0]  p_o
);

  localparam int unsigned H = mvva_pkg::MUL_W / 2;

  logic [2*H-1:0]                   ll_q, lh_q, hl_q, hh_q;
  logic [2*mvva_pkg::MUL_W-1:0]     p_q;

  // partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= a_i[H-1:0] * b_i[H-1:0];
      lh_q <= a_i[H-1:0] * b_i[2*H-1:H];
      hl_q <= a_i[2*H-1:H] * b_i[H-1:0];
      hh_q <= a_i[2*H-1:H] * b_i[2*H-1:H];
    end
  end

  // recombine
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= {hh_q, ll_q}
           + ({{(2*H){1'b0}}, lh_q} << H)
           + ({{(2*H){1'b0}}, hl_q} << H);
    end
  end

  assign p_o = p_q;

endmodule

[sv/mvva_sqrt.sv]
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Depends on mvva_pkg.
`timescale 1ns / 1ps
module mvva_sqrt (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [mvva_pkg::SQ_W-1:0]     rad_i,
  output logic [mvva_pkg::ROOT_W-1:0]   root_o
);

  localparam int unsigned N     = mvva_pkg::ROOT_W;
  localparam int unsigned RAD_W = 2 * N;
  localparam int unsigned REM_W = N + 4;

  logic [RAD_W-1:0] rad_q  [N];
  logic [REM_W-1:0] rem_q  [N];
  logic [N-1:0]     root_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [RAD_W-1:0] rad_in;
    logic [REM_W-1:0] rem_in;
    logic [N-1:0]     root_in;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign rad_in  = {{(RAD_W - mvva_pkg::SQ_W){1'b0}}, rad_i};
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // bring down two radicand bits, try root*4+1
    assign rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
    assign trial  = {{(REM_W-N-2){1'b0}}, root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= {rad_in[RAD_W-3:0], 2'b00};
        rem_q[k]  <= ge ? (rem_sh - trial) : rem_sh;
        root_q[k] <= {root_in[N-2:0], ge};
      end
    end
  end

  assign root_o = root_q[N-1];

endmodule

[sv/mvva_div.sv]
// Pipelined restoring divider with saturation: floor(num/den) clipped to the area range.
// Depends on mvva_pkg.
`timescale 1ns / 1ps
module mvva_div (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [mvva_pkg::SQ_W-1:0]     num_i,
  input  logic [mvva_pkg::DEN_W-1:0]    den_i,
  output logic [mvva_pkg::AREA_W-1:0]   quo_o
);

  localparam int unsigned Q  = mvva_pkg::AREA_W;
  localparam int unsigned NW = mvva_pkg::SQ_W;
  localparam int unsigned DW = mvva_pkg::DEN_W;
  localparam int unsigned CW = NW + 2;

  logic          sat0_q;
  logic [DW-1:0] rem0_q;
  logic [Q-1:0]  low0_q;
  logic [DW-1:0] den0_q;

  logic          sat_q [Q];
  logic [DW-1:0] rem_q [Q];
  logic [Q-1:0]  low_q [Q];
  logic [DW-1:0] den_q [Q];

  // quotient overflows the area range exactly when num >= den * 2^Q
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sat0_q <= ({{(CW-NW){1'b0}}, num_i} >= ({{(CW-DW){1'b0}}, den_i} << Q));
      rem0_q <= {{(DW-(NW-Q)){1'b0}}, num_i[NW-1:Q]};
      low0_q <= num_i[Q-1:0];
      den0_q <= den_i;
    end
  end

  for (genvar k = 0; k < Q; k++) begin : g_stage
    logic          sat_in;
    logic [DW-1:0] rem_in;
    logic [Q-1:0]  low_in;
    logic [DW-1:0] den_in;
    logic [DW:0]   rem_sh;
    logic          ge;

    if (k == 0) begin : g_first
      assign sat_in = sat0_q;
      assign rem_in = rem0_q;
      assign low_in = low0_q;
      assign den_in = den0_q;
    end else begin : g_next
      assign sat_in = sat_q[k-1];
      assign rem_in = rem_q[k-1];
      assign low_in = low_q[k-1];
      assign den_in = den_q[k-1];
    end

    // low word shifts out its top bit while quotient bits shift in at the bottom
    assign rem_sh = {rem_in, low_in[Q-1]};
    assign ge     = (rem_sh >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sat_q[k] <= sat_in;
        rem_q[k] <= ge ? DW'(rem_sh - {1'b0, den_in}) : rem_sh[DW-1:0];
        low_q[k] <= {low_in[Q-2:0], ge};
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = sat_q[Q-1] ? {Q{1'b1}} : low_q[Q-1];

endmodule

[sv/mixed_voronoi_vertex_area.sv]
// Mixed Voronoi vertex areas of one triangle; top level with the front-end arithmetic.
// Depends on mvva_pkg, mvva_if, mvva_delay, mvva_mul, mvva_sqrt and mvva_div.
//
// Takes one triangle word per cycle, unless the output stalls, and returns its three
// vertex areas in Q17.16 with a degenerate flag. Throughput is one triangle per clock;
// the latency is set by the 36-stage square root of the squared cross magnitude and the
// 34-stage dividers for the general case. A stall on the output holds the whole pipeline,
// so the input is ready whenever the output register is empty or being taken.
`timescale 1ns / 1ps
module mixed_voronoi_vertex_area (
  input  logic     clk_i,
  input  logic     rst_ni,
  mvva_in_if.sink    in_i,
  mvva_out_if.source out_o
);

  localparam int unsigned LAT = mvva_pkg::PIPE_LAT;
  localparam int unsigned MW  = mvva_pkg::MUL_W;

  logic           en;
  logic [LAT-1:0] vld_q;

  assign en       = ~vld_q[LAT-1] | out_o.ready;
  assign in_i.ready = en;

  // valid bits travel with the words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_i.valid};
    end
  end

  // stage 1: edge vectors
  logic signed [16:0] ab_q [3];
  logic signed [16:0] ac_q [3];
  logic signed [16:0] bc_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      ab_q[0] <= 17'(in_i.data.b_x) - 17'(in_i.data.a_x);
      ab_q[1] <= 17'(in_i.data.b_y) - 17'(in_i.data.a_y);
      ab_q[2] <= 17'(in_i.data.b_z) - 17'(in_i.data.a_z);
      ac_q[0] <= 17'(in_i.data.c_x) - 17'(in_i.data.a_x);
      ac_q[1] <= 17'(in_i.data.c_y) - 17'(in_i.data.a_y);
      ac_q[2] <= 17'(in_i.data.c_z) - 17'(in_i.data.a_z);
      bc_q[0] <= 17'(in_i.data.c_x) - 17'(in_i.data.b_x);
      bc_q[1] <= 17'(in_i.data.c_y) - 17'(in_i.data.b_y);
      bc_q[2] <= 17'(in_i.data.c_z) - 17'(in_i.data.b_z);
    end
  end

  // stage 2: component products (cross terms, then dot and length terms)
  logic signed [33:0] xp_q [6];
  logic signed [33:0] dp_q [6][3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      xp_q[0] <= ab_q[1] * ac_q[2];
      xp_q[1] <= ab_q[2] * ac_q[1];
      xp_q[2] <= ab_q[2] * ac_q[0];
      xp_q[3] <= ab_q[0] * ac_q[2];
      xp_q[4] <= ab_q[0] * ac_q[1];
      xp_q[5] <= ab_q[1] * ac_q[0];
      for (int k = 0; k < 3; k++) begin
        dp_q[0][k] <= ab_q[k] * ac_q[k];
        dp_q[1][k] <= ab_q[k] * bc_q[k];
        dp_q[2][k] <= ac_q[k] * bc_q[k];
        dp_q[3][k] <= ab_q[k] * ab_q[k];
        dp_q[4][k] <= ac_q[k] * ac_q[k];
        dp_q[5][k] <= bc_q[k] * bc_q[k];
      end
    end
  end

  // stage 3: cross components, dots at each vertex, squared edge lengths
  logic signed [34:0] cr_q [3];
  logic signed [35:0] dot_q [3];
  logic [33:0]        len_q [3];
  logic signed [35:0] dsum [6];

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      dsum[j] = 36'(dp_q[j][0]) + 36'(dp_q[j][1]) + 36'(dp_q[j][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cr_q[0]  <= 35'(xp_q[0]) - 35'(xp_q[1]);
      cr_q[1]  <= 35'(xp_q[2]) - 35'(xp_q[3]);
      cr_q[2]  <= 35'(xp_q[4]) - 35'(xp_q[5]);
      dot_q[0] <= dsum[0];
      dot_q[1] <= -dsum[1];
      dot_q[2] <= dsum[2];
      len_q[0] <= dsum[3][33:0];
      len_q[1] <= dsum[4][33:0];
      len_q[2] <= dsum[5][33:0];
    end
  end

  // stage 4: magnitudes and case flags
  logic [34:0]               acr_q [3];
  logic [34:0]               udot_q [3];
  logic [33:0]               ulen_q [3];
  mvva_pkg::case_flags_t     flg_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        acr_q[k]  <= cr_q[k][34] ? 35'(-cr_q[k]) : 35'(cr_q[k]);
        udot_q[k] <= dot_q[k][34:0];
        ulen_q[k] <= len_q[k];
      end
      flg_q.degen <= (cr_q[0] == '0) && (cr_q[1] == '0) && (cr_q[2] == '0);
      flg_q.obt_a <= dot_q[0][35];
      flg_q.obt_b <= dot_q[1][35];
      flg_q.obt_c <= dot_q[2][35];
    end
  end

  // stages 5-6: squares of the cross components and length-times-cotangent terms
  logic [2*MW-1:0] sqp [3];
  logic [2*MW-1:0] tp  [3];

  for (genvar k = 0; k < 3; k++) begin : g_sq
    mvva_mul u_sq (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   ({1'b0, acr_q[k]}),
      .b_i   ({1'b0, acr_q[k]}),
      .p_o   (sqp[k])
    );
  end

  // edge AB pairs with the dot at C, AC with B, BC with A
  for (genvar k = 0; k < 3; k++) begin : g_term
    mvva_mul u_term (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   ({2'b00, ulen_q[k]}),
      .b_i   ({1'b0, udot_q[2-k]}),
      .p_o   (tp[k])
    );
  end

  // stage 7: squared magnitude and the three numerators
  logic [mvva_pkg::SQ_W-1:0] sq_q;
  logic [mvva_pkg::SQ_W-1:0] num_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q     <= mvva_pkg::SQ_W'(sqp[0] + sqp[1] + sqp[2]);
      num_q[0] <= mvva_pkg::SQ_W'(tp[0] + tp[1]);
      num_q[1] <= mvva_pkg::SQ_W'(tp[0] + tp[2]);
      num_q[2] <= mvva_pkg::SQ_W'(tp[1] + tp[2]);
    end
  end

  // cross magnitude
  logic [mvva_pkg::ROOT_W-1:0] mag;

  mvva_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sq_q),
    .root_o (mag)
  );

  // divide by eight times the magnitude
  logic [mvva_pkg::SQ_W-1:0]   num_al [3];
  logic [mvva_pkg::AREA_W-1:0] quo [3];

  for (genvar k = 0; k < 3; k++) begin : g_div
    mvva_delay #(
      .WIDTH (mvva_pkg::SQ_W),
      .DEPTH (mvva_pkg::SQRT_LAT)
    ) u_num_dly (
      .clk_i (clk_i),
      .en_i  (en),
      .d_i   (num_q[k]),
      .q_o   (num_al[k])
    );

    mvva_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num_al[k]),
      .den_i ({mag, 3'b000}),
      .quo_o (quo[k])
    );
  end

  // side data aligned with the divider outputs
  logic [mvva_pkg::ROOT_W-1:0] mag_al;
  mvva_pkg::case_flags_t       flg_al;

  mvva_delay #(
    .WIDTH (mvva_pkg::ROOT_W),
    .DEPTH (mvva_pkg::DIV_LAT)
  ) u_mag_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (mag),
    .q_o   (mag_al)
  );

  mvva_delay #(
    .WIDTH ($bits(mvva_pkg::case_flags_t)),
    .DEPTH (3 + mvva_pkg::SQRT_LAT + mvva_pkg::DIV_LAT)
  ) u_flg_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (flg_q),
    .q_o   (flg_al)
  );

  // final selection: degenerate, first obtuse vertex, or the cotangent formula
  mvva_pkg::out_word_t res_d, res_q;
  logic [mvva_pkg::AREA_W-1:0] quarter, eighth;

  assign quarter = mag_al[mvva_pkg::AREA_W+1:2];
  assign eighth  = mag_al[mvva_pkg::AREA_W+2:3];

  always_comb begin
    res_d.degenerate = 1'b0;
    priority if (flg_al.degen) begin
      res_d.area_a     = '0;
      res_d.area_b     = '0;
      res_d.area_c     = '0;
      res_d.degenerate = 1'b1;
    end else if (flg_al.obt_a) begin
      res_d.area_a = quarter;
      res_d.area_b = eighth;
      res_d.area_c = eighth;
    end else if (flg_al.obt_b) begin
      res_d.area_a = eighth;
      res_d.area_b = quarter;
      res_d.area_c = eighth;
    end else if (flg_al.obt_c) begin
      res_d.area_a = eighth;
      res_d.area_b = eighth;
      res_d.area_c = quarter;
    end else begin
      res_d.area_a = quo[0];
      res_d.area_b = quo[1];
      res_d.area_c = quo[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid = vld_q[LAT-1];
  assign out_o.data  = res_q;

endmodule
